[sv/assert_macros.svh]
// Assertion macros used by the decoder RTL.
// Depends on nothing; the users supply clock and reset names as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error("assertion failed");
// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond)
`endif
`endif

[sv/cppm_pkg.sv]
// Package for the combined-PPM frame decoder: constants, state and result types,
// and the slot to channel remap function. Depends on nothing.
package cppm_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SLOT_W       = 4;
    localparam int TIME_W       = 16;
    localparam int CHAN_W       = 3;

    localparam logic [SLOT_W-1:0] SLOT_LIMIT = 4'd15;
    localparam logic [SLOT_W-1:0] SLOT_MAX   = SLOT_W'(MAX_CHANNELS);
    localparam logic [TIME_W-1:0] SYNC_RESET = 16'd3000;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [SLOT_W-1:0] highest_slot;
        logic [TIME_W-1:0] last_edge_time;
        logic [TIME_W-1:0] pulse_start;
    } state_t;

    typedef struct packed {
        logic              width_valid;
        logic [CHAN_W-1:0] channel_index;
        logic [TIME_W-1:0] pulse_width;
        logic              sync_seen;
        logic              frame_done;
        logic [SLOT_W-1:0] channel_count;
    } result_t;

    // Slots 1, 2, 3 map to channels 3, 1, 2; slot k above that maps to channel k.
    function automatic logic [CHAN_W-1:0] remap_slot(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] less_one;
        less_one = slot - 4'd1;
        unique case (slot)
            4'd1:    remap_slot = 3'd2;
            4'd2:    remap_slot = 3'd0;
            4'd3:    remap_slot = 3'd1;
            default: remap_slot = less_one[CHAN_W-1:0];
        endcase
    endfunction

endpackage

[sv/cppm_edge_logic.sv]
// Combinational handling of one edge: computes the next decoder state and the
// result item from the current state. Depends on cppm_pkg.
module cppm_edge_logic (
    input  cppm_pkg::state_t         state_cur,
    input  logic [15:0]              edge_time,
    input  logic [15:0]              sync_threshold,
    output cppm_pkg::state_t         state_nxt,
    output cppm_pkg::result_t        result
);

    logic [15:0] gap;
    logic        sync;
    logic [3:0]  slot_base;

    assign gap  = edge_time - state_cur.last_edge_time;
    assign sync = gap > sync_threshold;
    assign slot_base = sync ? 4'd0 : state_cur.slot_index;

    always_comb
    begin
        state_nxt                = state_cur;
        state_nxt.last_edge_time = edge_time;
        result                   = '0;
        result.sync_seen         = sync;

        if (slot_base == 4'd0)
        begin
            state_nxt.pulse_start = edge_time;
            state_nxt.slot_index  = 4'd1;
        end
        else if (slot_base <= cppm_pkg::SLOT_MAX)
        begin
            result.width_valid    = 1'b1;
            result.channel_index  = cppm_pkg::remap_slot(slot_base);
            result.pulse_width    = edge_time - state_cur.pulse_start;
            state_nxt.pulse_start = edge_time;
            state_nxt.slot_index  = (slot_base < cppm_pkg::SLOT_LIMIT) ?
                                    slot_base + 4'd1 : slot_base;
        end
        else
        begin
            state_nxt.slot_index = slot_base;
        end

        if (state_nxt.slot_index > state_cur.highest_slot)
            state_nxt.highest_slot = state_nxt.slot_index;
        else if (state_nxt.slot_index == state_cur.highest_slot)
            result.frame_done = 1'b1;

        result.channel_count = state_nxt.highest_slot;
    end

endmodule

[sv/cppm_frame_decoder.sv]
// Top level of the combined-PPM frame decoder: handshakes, state registers,
// result register and checks. Depends on cppm_pkg, cppm_edge_logic, assert_macros.svh.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+----------------------------------------------
//  config  | cfg_valid / cfg_ready  | cfg_data (sync_threshold, 16 bit)
//  input   | in_valid / in_ready    | edge_time
//  output  | out_valid / out_ready  | width_valid, channel_index, pulse_width,
//          |                        | sync_seen, frame_done, channel_count
//
// Each edge item is handled combinationally: the edge logic works on the state
// registers and the incoming timestamp, and its result is written into the output
// register when the item is accepted. A new item is taken in every cycle in
// which the output register is empty or is being emptied, so the sustained rate
// is one item per clock. Reset clears the slot counters, both timestamps and the
// output valid flag, and loads the sync threshold with 3000 ticks. The config
// port is always ready.
`include "assert_macros.svh"

module cppm_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] edge_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        width_valid,
    output logic [2:0]  channel_index,
    output logic [15:0] pulse_width,
    output logic        sync_seen,
    output logic        frame_done,
    output logic [3:0]  channel_count
);

    cppm_pkg::state_t  state_reg;
    cppm_pkg::state_t  state_next;
    cppm_pkg::result_t result_next;
    cppm_pkg::result_t result_reg;
    logic [15:0]       threshold_reg;
    logic              out_valid_reg;
    logic              in_fire;

    // The output register frees up in the same cycle it is read out, so the
    // input side only stalls while a result is held and not being taken.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    cppm_edge_logic u_edge (
        .state_cur      (state_reg),
        .edge_time      (edge_time),
        .sync_threshold (threshold_reg),
        .state_nxt      (state_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= cppm_pkg::SYNC_RESET;
        end
        else if (cfg_valid)
        begin
            threshold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                state_reg <= state_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign width_valid   = result_reg.width_valid;
    assign channel_index = result_reg.channel_index;
    assign pulse_width   = result_reg.pulse_width;
    assign sync_seen     = result_reg.sync_seen;
    assign frame_done    = result_reg.frame_done;
    assign channel_count = result_reg.channel_count;

    // The slot counter never runs ahead of the learned highest count.
    `ASSERT_CLK(a_slot_below_highest, clk, rst_n, state_reg.slot_index <= state_reg.highest_slot)
    // A reported width always leaves at least two slots learned.
    `ASSERT_CLK(a_width_count, clk, rst_n, (out_valid && width_valid) |-> (channel_count >= 4'd2))
    // Without a width, the channel and width fields read as zero.
    `ASSERT_CLK(a_idle_fields, clk, rst_n,
                (out_valid && !width_valid) |-> (channel_index == 3'd0 && pulse_width == 16'd0))
    // A held result blocks new input.
    `ASSERT_NEVER(a_no_overrun, clk, rst_n, out_valid && !out_ready && in_ready)

endmodule
